// File: hw/rtl/prrd_pkg.sv
package prrd_pkg;

    localparam int DEF_MAX_TASKS = 32;
    localparam logic [15:0] QUANTUM_RESET = 16'd10;

    localparam logic REQ_ADD      = 1'b0;
    localparam logic REQ_DISPATCH = 1'b1;

    localparam logic [1:0] ST_ADDED = 2'd0;
    localparam logic [1:0] ST_RAN   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  prio;
        logic [15:0] rem;
        logic [15:0] orig;
    } t_entry;

    typedef struct packed {
        logic wr_en;
        logic pop;
    } t_q_ctrl;

endpackage

// File: hw/rtl/prrd_queue.sv
module prrd_queue #(
    parameter int MAX_TASKS = prrd_pkg::DEF_MAX_TASKS,
    localparam int IW = $clog2(MAX_TASKS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  prrd_pkg::t_q_ctrl i_ctrl,
    input  logic [IW-1:0]    i_rd_pos,
    input  logic [IW-1:0]    i_wr_pos,
    input  prrd_pkg::t_entry i_wr_data,
    output prrd_pkg::t_entry o_rd_data
);
    import prrd_pkg::*;

    localparam int DEPTH = 2 ** IW;

    t_entry        mem [DEPTH];
    t_entry        r_rd_data;
    logic [IW-1:0] r_head;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;

    assign rd_addr   = r_head + i_rd_pos;
    assign wr_addr   = r_head + i_wr_pos;
    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
        end else if (i_ctrl.pop) begin
            r_head <= r_head + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            mem[wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

endmodule

// File: hw/rtl/priority_round_robin_dispatcher.sv
// Channel   Handshake                     Payload
// request   start in, busy out            i_req_type, i_task_id, i_task_priority,
//                                         i_burst_length
// result    o_strobe out (one cycle)      o_status, o_ran_id, o_run_length, o_finished,
//                                         o_turnaround, o_waiting
// config    i_cfg_valid in, o_cfg_ready   i_cfg_data (time quantum)
//
// Add: walk (S_WALK_RD, S_WALK) then S_INS_WR; to an empty queue straight to S_INS_WR.
// Slice: S_D_RD0, S_D_RD1, S_D_EVAL, then walk and S_INS_WR to re-queue, or S_FIN.
// Empty or full answer comes the cycle after the transfer.
// The queue walk moves one entry per cycle through a memory with one read and one write port.
// Synchronous active-low reset empties the queue and clears the clock.
// Results cannot be stalled; each one is shown for exactly one cycle.
module priority_round_robin_dispatcher #(
    parameter int MAX_TASKS = prrd_pkg::DEF_MAX_TASKS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [7:0]  i_task_id,
    input  logic [7:0]  i_task_priority,
    input  logic [15:0] i_burst_length,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [7:0]  o_ran_id,
    output logic [15:0] o_run_length,
    output logic        o_finished,
    output logic [31:0] o_turnaround,
    output logic [31:0] o_waiting,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import prrd_pkg::*;

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_WALK_RD = 8'b0000_0010,
        S_WALK    = 8'b0000_0100,
        S_INS_WR  = 8'b0000_1000,
        S_D_RD0   = 8'b0001_0000,
        S_D_RD1   = 8'b0010_0000,
        S_D_EVAL  = 8'b0100_0000,
        S_FIN     = 8'b1000_0000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_pos, n_pos;
    logic [31:0]   r_elapsed, n_elapsed;
    logic [15:0]   r_quantum;
    t_entry        r_ins, n_ins;
    logic          r_disp, n_disp;
    logic          r_strobe, n_strobe;
    logic [1:0]    r_status, n_status;
    logic [7:0]    r_ran_id, n_ran_id;
    logic [15:0]   r_run_len, n_run_len;
    logic          r_fin, n_fin;
    logic [31:0]   r_turn, n_turn;
    logic [31:0]   r_wait, n_wait;

    t_q_ctrl       q_ctrl;
    logic [IW-1:0] rd_pos;
    logic [IW-1:0] wr_pos;
    t_entry        wr_data;
    t_entry        q_rd_data;
    logic [15:0]   quantum;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] cnt_m2;
    logic          shares;

    prrd_queue #(
        .MAX_TASKS (MAX_TASKS)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (q_ctrl),
        .i_rd_pos  (rd_pos),
        .i_wr_pos  (wr_pos),
        .i_wr_data (wr_data),
        .o_rd_data (q_rd_data)
    );

    assign busy         = (r_state != S_IDLE);
    assign o_cfg_ready  = (r_state == S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_ran_id     = r_ran_id;
    assign o_run_length = r_run_len;
    assign o_finished   = r_fin;
    assign o_turnaround = r_turn;
    assign o_waiting    = r_wait;

    assign quantum = (r_quantum == 16'd0) ? 16'd1 : r_quantum;
    assign cnt_m1  = r_count - CW'(1);
    assign cnt_m2  = r_count - CW'(2);
    assign shares  = (r_count > CW'(1)) && (q_rd_data.prio >= r_ins.prio);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_elapsed = r_elapsed;
        n_ins     = r_ins;
        n_disp    = r_disp;
        n_strobe  = 1'b0;
        n_status  = r_status;
        n_ran_id  = r_ran_id;
        n_run_len = r_run_len;
        n_fin     = r_fin;
        n_turn    = r_turn;
        n_wait    = r_wait;
        q_ctrl    = '0;
        rd_pos    = '0;
        wr_pos    = r_pos;
        wr_data   = r_ins;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_disp = i_req_type;
                    if (i_req_type == REQ_ADD) begin
                        if (r_count >= CW'(MAX_TASKS)) begin
                            n_strobe  = 1'b1;
                            n_status  = ST_FULL;
                            n_ran_id  = '0;
                            n_run_len = '0;
                            n_fin     = 1'b0;
                            n_turn    = '0;
                            n_wait    = '0;
                        end else begin
                            n_ins.id   = i_task_id;
                            n_ins.prio = i_task_priority;
                            n_ins.rem  = i_burst_length;
                            n_ins.orig = i_burst_length;
                            if (r_count == '0) begin
                                n_pos   = '0;
                                n_state = S_INS_WR;
                            end else begin
                                n_pos   = cnt_m1[IW-1:0];
                                n_state = S_WALK_RD;
                            end
                        end
                    end else if (r_count == '0) begin
                        n_strobe  = 1'b1;
                        n_status  = ST_EMPTY;
                        n_ran_id  = '0;
                        n_run_len = '0;
                        n_fin     = 1'b0;
                        n_turn    = '0;
                        n_wait    = '0;
                    end else begin
                        n_state = S_D_RD0;
                    end
                end
            end
            S_WALK_RD: begin
                rd_pos  = r_pos;
                n_state = S_WALK;
            end
            S_WALK: begin
                rd_pos = r_pos - 1'b1;
                if (q_rd_data.prio >= r_ins.prio) begin
                    n_pos   = r_pos + 1'b1;
                    n_state = S_INS_WR;
                end else begin
                    // shift this entry one place toward the tail
                    q_ctrl.wr_en = 1'b1;
                    wr_pos       = r_pos + 1'b1;
                    wr_data      = q_rd_data;
                    if (r_pos == '0) begin
                        n_state = S_INS_WR;
                    end else begin
                        n_pos = r_pos - 1'b1;
                    end
                end
            end
            S_INS_WR: begin
                q_ctrl.wr_en = 1'b1;
                wr_pos       = r_pos;
                wr_data      = r_ins;
                n_count      = r_count + 1'b1;
                n_strobe     = 1'b1;
                n_status     = r_disp ? ST_RAN : ST_ADDED;
                n_ran_id     = r_disp ? r_ins.id : 8'd0;
                n_run_len    = r_disp ? r_run_len : 16'd0;
                n_fin        = 1'b0;
                n_turn       = '0;
                n_wait       = '0;
                n_state      = S_IDLE;
            end
            S_D_RD0: begin
                rd_pos  = '0;
                n_state = S_D_RD1;
            end
            S_D_RD1: begin
                rd_pos  = IW'(1);
                n_ins   = q_rd_data;
                n_state = S_D_EVAL;
            end
            S_D_EVAL: begin
                q_ctrl.pop = 1'b1;
                n_count    = cnt_m1;
                if ((r_ins.rem <= quantum) || !shares) begin
                    n_elapsed = r_elapsed + 32'(r_ins.rem);
                    n_run_len = r_ins.rem;
                    n_state   = S_FIN;
                end else begin
                    n_ins.rem = r_ins.rem - quantum;
                    n_elapsed = r_elapsed + 32'(quantum);
                    n_run_len = quantum;
                    n_pos     = cnt_m2[IW-1:0];
                    n_state   = S_WALK_RD;
                end
            end
            S_FIN: begin
                n_strobe = 1'b1;
                n_status = ST_RAN;
                n_ran_id = r_ins.id;
                n_fin    = 1'b1;
                n_turn   = r_elapsed;
                n_wait   = r_elapsed - 32'(r_ins.orig);
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_elapsed <= '0;
            r_quantum <= QUANTUM_RESET;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_elapsed <= n_elapsed;
            r_strobe  <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_quantum <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_ins     <= n_ins;
        r_disp    <= n_disp;
        r_status  <= n_status;
        r_ran_id  <= n_ran_id;
        r_run_len <= n_run_len;
        r_fin     <= n_fin;
        r_turn    <= n_turn;
        r_wait    <= n_wait;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_TASKS))
        else $error("queue count above capacity");

    a_accept_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted request neither started nor answered");

    a_strobe_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN || r_state == S_INS_WR) |=> (o_strobe && !busy))
        else $error("result not issued at end of sequence");

    a_finish_is_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_finished) |-> (o_status == ST_RAN))
        else $error("finished flag on a non-run result");

endmodule
